// File: sv/sorted_read_to_gene_counter_assert.svh
// Assertion macros for the gene counter checker.
// Used only by files that hold concurrent assertions; needs clk and rst_n in scope.
`ifndef SORTED_READ_TO_GENE_COUNTER_ASSERT_SVH
`define SORTED_READ_TO_GENE_COUNTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRGC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srgc assertion failed");

// Next-cycle implication, checked outside reset.
`define SRGC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srgc assertion failed");

`endif

// File: sv/srgc_pkg.sv
// Shared types and codes for the sorted read to gene counter.
// No dependencies; used by the interfaces, the top level and the checker.
package srgc_pkg;

  localparam int GENE_SLOTS_DEF = 1024;
  localparam int REF_IDS_DEF    = 256;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_CIGAR = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_NO_SLOT = 2'd2;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_I    = 8'h49;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  ref_id;
    logic [30:0] read_start;
    logic [7:0]  cigar_char;
    logic        last_char;
    logic [30:0] gene_start;
    logic [30:0] gene_end;
    logic [9:0]  gene_slot_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        counted;
    logic [9:0]  gene_slot;
    logic [31:0] read_end;
    logic [31:0] total_reads;
    logic [31:0] gene_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  ref_id;
    logic [30:0] gstart;
    logic [30:0] gend;
  } entry_t;

endpackage

// File: sv/srgc_in_if.sv
// Input channel of the gene counter: valid/ready with one input item.
// Depends on srgc_pkg.
interface srgc_in_if import srgc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: sv/srgc_out_if.sv
// Result channel of the gene counter: valid/ready with one result item.
// Depends on srgc_pkg.
interface srgc_out_if import srgc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: sv/sorted_read_to_gene_counter.sv
// Counts aligned reads against a sorted gene table held in two simple
// dual-port memories (entry and count), each with a registered read.
// A CIGAR character without the last mark is taken in the idle state. A
// last character walks the cursor over the genes it steps over, reading
// one entry per step. A gene load scans the entries below the new key and
// shifts later entries up, or stops at a duplicate or a full table. A count
// readout reads the count memory, or skips it for a slot not loaded. All
// table accesses share the one read port of the table memories. Results
// leave through an output register; while it still holds an unaccepted
// result, the next result waits, and the input is not ready while it waits.
// Depends on srgc_pkg, srgc_in_if and srgc_out_if.
module sorted_read_to_gene_counter import srgc_pkg::*; #(
  parameter int GENE_SLOTS = GENE_SLOTS_DEF,
  parameter int REF_IDS    = REF_IDS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  srgc_in_if.sink   in_chan,
  srgc_out_if.source out_chan
);

  localparam int SLOT_W = (GENE_SLOTS > 1) ? $clog2(GENE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(GENE_SLOTS + 1);
  localparam logic [16:0] REF_LIM = 17'(REF_IDS);
  localparam logic [7:0]  REF_MAX = 8'(REF_IDS - 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(GENE_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_LRD, S_LCMP, S_SHRD, S_SHWR, S_INS, S_WRD, S_WCMP, S_CRD, S_CDAT, S_EMIT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  loaded_r, cursor_r, idx_r, pos_r;
  logic [7:0]        cur_ref_r;
  logic              cur_vld_r, find_r;
  logic [31:0]       acc_r, span_r, total_r, rend_r;
  entry_t            key_r;
  logic [30:0]       rstart_r;
  out_item_t         res_r, out_r;
  logic              out_valid_r;
  logic              out_valid_nxt;

  entry_t            ent_mem [GENE_SLOTS];
  logic [31:0]       cnt_mem [GENE_SLOTS];
  entry_t            ent_q, ent_wd;
  logic [31:0]       cnt_q, cnt_wd, cnt_inc;
  logic              ent_we, cnt_we;
  logic [SLOT_W-1:0] rd_addr, wr_addr;

  in_item_t          it;
  logic              acc_ok;
  logic [7:0]        ref_c;
  logic              is_dig;
  logic [35:0]       acc_wide;
  logic [32:0]       span_wide, end_wide;
  logic [31:0]       acc_nxt, span_nxt, rend_nxt, total_nxt;
  logic              key_lt, key_eq;
  logic              emit_ok;
  logic [CNT_W-1:0]  idx_dec;
  logic              slot_miss;
  out_item_t         res_start;

  assign it      = in_chan.data;
  assign acc_ok  = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;
  assign emit_ok = !out_valid_r || out_chan.ready;
  assign idx_dec = idx_r - CNT_W'(1);
  assign out_valid_nxt = (state_r == S_EMIT && emit_ok) || (out_valid_r && !out_chan.ready);

  assign ref_c = ({9'd0, it.ref_id} >= REF_LIM) ? REF_MAX : it.ref_id;

  // CIGAR arithmetic, all saturating at 32 bits.
  always_comb begin
    is_dig    = (it.cigar_char >= CH_ZERO) && (it.cigar_char <= CH_NINE);
    acc_wide  = {4'd0, acc_r} * 36'd10 + {32'd0, it.cigar_char[3:0]};
    span_wide = {1'b0, span_r} + {1'b0, acc_r};
    acc_nxt   = 32'd0;
    span_nxt  = span_r;
    if (is_dig) begin
      acc_nxt = (acc_wide > {4'd0, SAT32}) ? SAT32 : acc_wide[31:0];
    end else if (it.cigar_char == CH_M || it.cigar_char == CH_N || it.cigar_char == CH_D) begin
      span_nxt = span_wide[32] ? SAT32 : span_wide[31:0];
    end
    end_wide = {2'd0, it.read_start} + {1'b0, span_nxt};
    if (end_wide == 33'd0) begin
      rend_nxt = 32'd0;
    end else if (end_wide[32] && end_wide[31:0] != 32'd0) begin
      rend_nxt = SAT32;
    end else begin
      rend_nxt = 32'(end_wide - 33'd1);
    end
    total_nxt = (total_r == SAT32) ? SAT32 : total_r + 32'd1;
    cnt_inc   = (cnt_q == SAT32) ? SAT32 : cnt_q + 32'd1;
  end

  // Result fields known at the accepting edge.
  always_comb begin
    slot_miss = ({7'd0, it.gene_slot_in} >= 17'(loaded_r));
    res_start = '0;
    res_start.total_reads = total_r;
    if (it.mode == MODE_CIGAR && it.last_char) begin
      res_start.total_reads = total_nxt;
      res_start.read_end    = rend_nxt;
    end
    if (it.mode == MODE_QUERY) begin
      res_start.gene_slot = it.gene_slot_in;
      if (slot_miss) res_start.status = STS_NO_SLOT;
    end
  end

  always_comb begin
    key_eq = (ent_q == key_r);
    key_lt = (ent_q.ref_id < key_r.ref_id) ||
             (ent_q.ref_id == key_r.ref_id && ent_q.gstart < key_r.gstart) ||
             (ent_q.ref_id == key_r.ref_id && ent_q.gstart == key_r.gstart &&
              ent_q.gend < key_r.gend);
  end

  // Memory port control.
  always_comb begin
    rd_addr = idx_r[SLOT_W-1:0];
    wr_addr = idx_r[SLOT_W-1:0];
    ent_we  = 1'b0;
    cnt_we  = 1'b0;
    ent_wd  = ent_q;
    cnt_wd  = cnt_q;
    unique case (state_r)
      S_SHRD: rd_addr = idx_dec[SLOT_W-1:0];
      S_WRD:  rd_addr = cursor_r[SLOT_W-1:0];
      S_LCMP: begin
        if (idx_r < loaded_r && !key_lt && key_eq) begin
          cnt_we = 1'b1;
          cnt_wd = 32'd0;
        end
      end
      S_SHWR: begin
        ent_we = 1'b1;
        cnt_we = 1'b1;
      end
      S_INS: begin
        wr_addr = pos_r[SLOT_W-1:0];
        ent_we  = 1'b1;
        cnt_we  = 1'b1;
        ent_wd  = key_r;
        cnt_wd  = 32'd0;
      end
      S_WCMP: begin
        wr_addr = cursor_r[SLOT_W-1:0];
        cnt_wd  = cnt_inc;
        if (cursor_r < loaded_r && !(find_r && ent_q.ref_id < key_r.ref_id) &&
            !(ent_q.ref_id == key_r.ref_id && ent_q.gend < rstart_r) &&
            ent_q.ref_id == key_r.ref_id && rend_r >= {1'b0, ent_q.gstart}) begin
          cnt_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[wr_addr] <= ent_wd;
    ent_q <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[wr_addr] <= cnt_wd;
    cnt_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      cursor_r    <= '0;
      cur_vld_r   <= 1'b0;
      acc_r       <= 32'd0;
      span_r      <= 32'd0;
      total_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (acc_ok) begin
            res_r <= res_start;
            unique case (it.mode)
              MODE_LOAD: begin
                key_r     <= '{ref_id: ref_c, gstart: it.gene_start, gend: it.gene_end};
                idx_r     <= '0;
                cursor_r  <= '0;
                cur_vld_r <= 1'b0;
                state_r   <= S_LRD;
              end
              MODE_CIGAR: begin
                acc_r  <= it.last_char ? 32'd0 : acc_nxt;
                span_r <= it.last_char ? 32'd0 : span_nxt;
                if (it.last_char) begin
                  rend_r    <= rend_nxt;
                  rstart_r  <= it.read_start;
                  key_r.ref_id <= ref_c;
                  total_r   <= total_nxt;
                  // A new reference restarts the cursor and searches from the top.
                  find_r    <= !cur_vld_r || cur_ref_r != ref_c;
                  if (!cur_vld_r || cur_ref_r != ref_c) cursor_r <= '0;
                  cur_ref_r <= ref_c;
                  cur_vld_r <= 1'b1;
                  state_r   <= S_WRD;
                end
              end
              MODE_QUERY: begin
                if (slot_miss) begin
                  state_r <= S_EMIT;
                end else begin
                  idx_r   <= CNT_W'(it.gene_slot_in);
                  state_r <= S_CRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_LRD: state_r <= S_LCMP;
        S_LCMP: begin
          if (idx_r < loaded_r && key_lt) begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= S_LRD;
          end else if (idx_r < loaded_r && key_eq) begin
            state_r <= S_EMIT;
          end else if (loaded_r >= SLOTS_C) begin
            res_r.status <= STS_FULL;
            state_r      <= S_EMIT;
          end else begin
            pos_r   <= idx_r;
            idx_r   <= loaded_r;
            state_r <= (loaded_r > idx_r) ? S_SHRD : S_INS;
          end
        end
        S_SHRD: state_r <= S_SHWR;
        S_SHWR: begin
          idx_r   <= idx_dec;
          state_r <= (idx_dec > pos_r) ? S_SHRD : S_INS;
        end
        S_INS: begin
          loaded_r <= loaded_r + CNT_W'(1);
          state_r  <= S_EMIT;
        end
        S_WRD: state_r <= S_WCMP;
        S_WCMP: begin
          if (cursor_r >= loaded_r) begin
            state_r <= S_EMIT;
          end else if (find_r && ent_q.ref_id < key_r.ref_id) begin
            cursor_r <= cursor_r + CNT_W'(1);
            state_r  <= S_WRD;
          end else if (ent_q.ref_id == key_r.ref_id && ent_q.gend < rstart_r) begin
            find_r   <= 1'b0;
            cursor_r <= cursor_r + CNT_W'(1);
            state_r  <= S_WRD;
          end else begin
            if (ent_q.ref_id == key_r.ref_id && rend_r >= {1'b0, ent_q.gstart}) begin
              res_r.counted   <= 1'b1;
              res_r.gene_slot <= 10'(cursor_r);
            end
            state_r <= S_EMIT;
          end
        end
        S_CRD: state_r <= S_CDAT;
        S_CDAT: begin
          res_r.gene_count <= cnt_q;
          state_r          <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/srgc_checker.sv
// Port-level checks for the gene counter, bound to the top level.
// Depends on srgc_pkg and sorted_read_to_gene_counter_assert.svh.
`include "sorted_read_to_gene_counter_assert.svh"

module srgc_checker import srgc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic counted_clean;
  logic no_slot_clean;

  assign counted_clean = out_data.status == STS_OK && out_data.gene_count == 32'd0;
  assign no_slot_clean = out_data.gene_count == 32'd0 && !out_data.counted &&
                         out_data.read_end == 32'd0;

  // A stalled result keeps its payload.
  `SRGC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // A counted read never carries an error status or a readout count.
  `SRGC_ASSERT_IMP(a_counted_ok, out_valid && out_data.counted, counted_clean)
  // A missing slot reads as zero and counts nothing.
  `SRGC_ASSERT_IMP(a_no_slot, out_valid && out_data.status == STS_NO_SLOT, no_slot_clean)

endmodule

bind sorted_read_to_gene_counter srgc_checker u_srgc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

// File: sim/tb_sorted_read_to_gene_counter.sv
// Self-checking testbench for sorted_read_to_gene_counter: drives gene loads,
// CIGAR reads and count readouts and checks every result against a predictor.
// Depends on srgc_pkg, srgc_in_if, srgc_out_if and the top level.
`timescale 1ns / 1ps
module tb_sorted_read_to_gene_counter;
  import srgc_pkg::*;

  localparam int SLOTS = 1024;
  localparam int REFS = 256;
  localparam int CYCLE_LIMIT = 10000000;

  logic clk;
  logic rst_n;
  srgc_in_if in_chan();
  srgc_out_if out_chan();

  sorted_read_to_gene_counter dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  // Predictor state.
  entry_t      gene_tab[SLOTS];
  logic [31:0] hits_tab[SLOTS];
  int          n_genes;
  int          walk_pos;
  int          walk_ref;
  bit          walk_ref_ok;
  logic [31:0] len_acc;
  logic [31:0] span_acc;
  logic [31:0] reads_done;

  out_item_t pending_results[$];
  int  failures;
  bit  send_quiet;     // no idling on the input side
  bit  recv_quiet;     // no stalls on the result side
  bit  recv_hold;      // long hold-off of the result side
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t timeout", $time);
        $display("[sorted_read_to_gene_counter] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

  function automatic int entry_order(int i, entry_t k);
    if (gene_tab[i].ref_id != k.ref_id) return gene_tab[i].ref_id < k.ref_id ? -1 : 1;
    if (gene_tab[i].gstart != k.gstart) return gene_tab[i].gstart < k.gstart ? -1 : 1;
    if (gene_tab[i].gend != k.gend) return gene_tab[i].gend < k.gend ? -1 : 1;
    return 0;
  endfunction

  // Returns 1 when the item produces a result, filled into r.
  function automatic bit predict_count(in_item_t it, output out_item_t r);
    int rid;
    int p;
    logic [32:0] v;
    logic [31:0] rend;
    logic [35:0] wide;
    entry_t k;
    bit hit;
    r = '0;
    rid = (it.ref_id >= REFS) ? REFS - 1 : it.ref_id;
    if (it.mode == MODE_LOAD) begin
      k.ref_id = 8'(rid); k.gstart = it.gene_start; k.gend = it.gene_end;
      p = 0;
      while (p < n_genes && entry_order(p, k) < 0) p++;
      walk_ref_ok = 0;
      walk_pos = 0;
      r.total_reads = reads_done;
      if (p < n_genes && entry_order(p, k) == 0) hits_tab[p] = 0;
      else if (n_genes >= SLOTS) r.status = STS_FULL;
      else begin
        for (int i = n_genes; i > p; i--) begin
          gene_tab[i] = gene_tab[i-1];
          hits_tab[i] = hits_tab[i-1];
        end
        gene_tab[p] = k;
        hits_tab[p] = 0;
        n_genes++;
      end
      return 1;
    end
    if (it.mode == MODE_QUERY) begin
      r.gene_slot = it.gene_slot_in;
      r.total_reads = reads_done;
      if (it.gene_slot_in >= n_genes) r.status = STS_NO_SLOT;
      else r.gene_count = hits_tab[it.gene_slot_in];
      return 1;
    end
    if (it.mode != MODE_CIGAR) return 0;
    if (it.cigar_char >= CH_ZERO && it.cigar_char <= CH_NINE) begin
      wide = {4'd0, len_acc} * 36'd10 + (it.cigar_char - CH_ZERO);
      len_acc = (wide > SAT32) ? SAT32 : wide[31:0];
    end else begin
      if (it.cigar_char == CH_M || it.cigar_char == CH_N || it.cigar_char == CH_D)
        span_acc = sat_inc(span_acc, len_acc);
      len_acc = 0;
    end
    if (!it.last_char) return 0;
    v = {2'b0, it.read_start} + {1'b0, span_acc};
    rend = (v == 0) ? 32'd0 : ((v - 1) > SAT32 ? SAT32 : 32'(v - 1));
    if (!walk_ref_ok || walk_ref != rid) begin
      walk_pos = 0;
      while (walk_pos < n_genes && gene_tab[walk_pos].ref_id < rid) walk_pos++;
      walk_ref = rid;
      walk_ref_ok = 1;
    end
    while (walk_pos < n_genes && gene_tab[walk_pos].ref_id == rid &&
           gene_tab[walk_pos].gend < it.read_start) walk_pos++;
    hit = walk_pos < n_genes && gene_tab[walk_pos].ref_id == rid &&
          rend >= gene_tab[walk_pos].gstart;
    if (hit) hits_tab[walk_pos] = sat_inc(hits_tab[walk_pos], 1);
    reads_done = sat_inc(reads_done, 1);
    len_acc = 0;
    span_acc = 0;
    r.counted = hit;
    r.gene_slot = hit ? walk_pos[9:0] : 10'd0;
    r.read_end = rend;
    r.total_reads = reads_done;
    return 1;
  endfunction

  function automatic in_item_t blank_item();
    in_item_t it;
    it = '0;
    it.read_start = 31'($urandom());
    it.gene_start = 31'($urandom());
    it.gene_end = 31'($urandom());
    it.gene_slot_in = 10'($urandom());
    it.cigar_char = 8'($urandom());
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    out_item_t r;
    while (!send_quiet && $urandom_range(99) < 24) @(negedge clk);
    in_chan.valid = 1'b1;
    in_chan.data = it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (predict_count(it, r)) pending_results.push_back(r);
    @(negedge clk);
    in_chan.valid = 1'b0;
    in_chan.data = blank_item();
  endtask

  task automatic send_gene(int rid, int gs, int ge);
    in_item_t it;
    it = blank_item();
    it.mode = MODE_LOAD; it.ref_id = 8'(rid); it.gene_start = 31'(gs); it.gene_end = 31'(ge);
    send_item(it);
  endtask

  task automatic send_query(int slot);
    in_item_t it;
    it = blank_item();
    it.mode = MODE_QUERY; it.gene_slot_in = 10'(slot);
    send_item(it);
  endtask

  // Sends the CIGAR text of one read, last mark on the final character.
  task automatic send_read(int rid, int rstart, string cig);
    in_item_t it;
    for (int i = 0; i < cig.len(); i++) begin
      it = blank_item();
      it.mode = MODE_CIGAR; it.ref_id = 8'(rid); it.read_start = 31'(rstart);
      it.cigar_char = cig[i];
      it.last_char = (i == cig.len() - 1);
      send_item(it);
    end
  endtask

  function automatic string random_cigar();
    string s;
    byte ops[7];
    int n;
    ops = '{"M", "N", "D", "S", "I", "H", "X"};
    s = "";
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++)
      s = {s, $sformatf("%0d%c", $urandom_range(1, 300), ops[$urandom_range(6)])};
    return s;
  endfunction

  // Result checker.
  initial begin
    out_item_t want;
    out_item_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got = out_chan.data;
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result %h", $time, got);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t status exp %0d got %0d", $time, want.status, got.status); failures++;
          end
          if (got.counted !== want.counted) begin
            $display("%0t counted exp %0d got %0d", $time, want.counted, got.counted);
            failures++;
          end
          if (got.gene_slot !== want.gene_slot) begin
            $display("%0t gene_slot exp %0d got %0d", $time, want.gene_slot, got.gene_slot);
            failures++;
          end
          if (got.read_end !== want.read_end) begin
            $display("%0t read_end exp %0d got %0d", $time, want.read_end, got.read_end);
            failures++;
          end
          if (got.total_reads !== want.total_reads) begin
            $display("%0t total_reads exp %0d got %0d", $time, want.total_reads,
                     got.total_reads);
            failures++;
          end
          if (got.gene_count !== want.gene_count) begin
            $display("%0t gene_count exp %0d got %0d", $time, want.gene_count,
                     got.gene_count);
            failures++;
          end
        end
      end
    end
  end

  // Result-side ready: random stalls, or a long counted hold-off.
  initial begin
    int held;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold) begin
        out_chan.ready <= 1'b0;
        for (held = 0; held < 400; held++) @(negedge clk);
        recv_hold = 0;
      end
      out_chan.ready <= recv_quiet || ($urandom_range(99) >= 24);
    end
  end

  task automatic test_directed_edges();
    send_query(0);                               // empty table readout
    send_read(0, 5, "10M");                      // read with no genes
    send_gene(0, 100, 200);
    send_gene(0, 50, 80);
    send_gene(0, 100, 200);                      // duplicate resets its count
    send_gene(3, 300, 250);                      // reversed gene
    send_gene(255, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_gene(0, 0, 0);
    send_read(0, 60, "5S10M2I3D4N1H");
    send_read(0, 150, "20M");
    send_read(0, 500, "1M");                     // cursor past end
    send_read(3, 260, "3M");
    send_read(200, 32'h7FFF_FFFF, "99999999999M"); // saturating length
    send_read(255, 0, "0M");                     // zero end
    send_read(1, 10, "7=");
    send_query(1);
    send_query(2);
    send_query(1023);
  endtask

  task automatic test_unused_mode();
    in_item_t it;
    it = blank_item();
    it.mode = 2'd3;
    it.last_char = 1'b1;
    send_item(it);
  endtask

  task automatic test_backpressure();
    recv_hold = 1;
    for (int i = 0; i < 60; i++) send_query($urandom_range(12));
  endtask

  task automatic test_random_traffic(int n_items);
    int sent;
    int rid;
    int r;
    string cig;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      rid = $urandom_range(0, 5) == 0 ? $urandom_range(255) : $urandom_range(3);
      if (r < 12) begin
        send_gene(rid, $urandom_range(0, 5000), $urandom_range(0, 5000));
        sent++;
      end else if (r < 22) begin
        send_query($urandom_range(0, n_genes + 2));
        sent++;
      end else if (r < 27) begin
        it = blank_item();
        it.mode = MODE_CIGAR;
        it.ref_id = 8'($urandom());
        it.read_start = 31'($urandom());
        it.last_char = 1'($urandom());
        send_item(it);
        sent++;
      end else begin
        cig = random_cigar();
        send_read(rid, $urandom_range(0, 5000), cig);
        sent += cig.len();
      end
      if (sent > n_items / 2 && sent < n_items / 2 + 80) send_quiet = 1;
      else send_quiet = 0;
      recv_quiet = send_quiet;
    end
  endtask

  task automatic test_full_table();
    // Fill to capacity on one reference with short sequential genes.
    for (int i = n_genes; i < SLOTS + 3; i++) send_gene(7, 100000 + i * 10, 100000 + i * 10);
    // Duplicate of the last entry that went in, sent while the table is full.
    send_gene(7, 100000 + (SLOTS - 1) * 10, 100000 + (SLOTS - 1) * 10);
    send_read(7, 100005, "30M");
    send_query(SLOTS - 1);
  endtask

  initial begin
    failures = 0;
    n_genes = 0; walk_pos = 0; walk_ref = 0; walk_ref_ok = 0;
    len_acc = 0; span_acc = 0; reads_done = 0;
    send_quiet = 0; recv_quiet = 0; recv_hold = 0;
    for (int i = 0; i < SLOTS; i++) hits_tab[i] = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_edges();
    test_unused_mode();
    test_backpressure();
    test_random_traffic(250);
    test_full_table();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (failures == 0) $display("[sorted_read_to_gene_counter] OK");
    else $display("[sorted_read_to_gene_counter] ERROR");
    $finish;
  end
endmodule
